### hw/rtl/aio_pkg.sv
// Shared types, register codes and fixed-point helpers for the alpha icon overlay.
// Used by alpha_icon_overlay and aio_blend; depends on nothing else.
package aio_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Configuration register codes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_ICON_WIDTH   = 3'd2,
        CFG_ICON_HEIGHT  = 3'd3,
        CFG_PLACE_X      = 3'd4,
        CFG_PLACE_Y      = 3'd5
    } cfg_idx_t;

    localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [6:0]  RST_ICON_WIDTH   = 7'd64;
    localparam logic [6:0]  RST_ICON_HEIGHT  = 7'd64;
    localparam logic [12:0] RST_PLACE_X      = 13'd50;
    localparam logic [12:0] RST_PLACE_Y      = 13'd50;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_t;

    // Stage enables handed to the blend datapath
    typedef struct packed {
        logic mul_en;
        logic out_en;
    } blend_ctl_t;

    // p*a + b*(255-a), at most 65025
    function automatic logic [15:0] blend_num(input logic [7:0] p, input logic [7:0] b,
                                              input logic [7:0] a);
        return 16'(p) * 16'(a) + 16'(b) * (16'd255 - 16'(a));
    endfunction

    // round(num / 255) for num <= 65025: reciprocal trick, exact over that range
    function automatic logic [7:0] div255_round(input logic [15:0] num);
        logic [15:0] x;
        logic [15:0] s;
        x = num + 16'd127;
        s = x + {8'd0, x[15:8]} + 16'd1;
        return s[15:8];
    endfunction

endpackage

### hw/rtl/aio_blend.sv
// Blend datapath: per-channel products, then rounded divide by 255.
// Depends on aio_pkg. Uncovered or alpha 0 pixels pass background.
module aio_blend
(
    input  logic               clk,
    input  aio_pkg::blend_ctl_t ctl,
    input  aio_pkg::pix_t      icon_pix,
    input  logic [7:0]         icon_alpha,
    input  logic               covered,
    input  aio_pkg::pix_t      bg_pix,
    output aio_pkg::pix_t      result
);
    import aio_pkg::*;

    logic [15:0] num_b_reg;
    logic [15:0] num_g_reg;
    logic [15:0] num_r_reg;
    pix_t        bg_reg;
    logic        use_reg;
    logic        use_next;
    pix_t        result_reg;

    assign use_next = covered && (icon_alpha != 8'd0);

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            num_b_reg <= blend_num(icon_pix.blue,  bg_pix.blue,  icon_alpha);
            num_g_reg <= blend_num(icon_pix.green, bg_pix.green, icon_alpha);
            num_r_reg <= blend_num(icon_pix.red,   bg_pix.red,   icon_alpha);
            bg_reg    <= bg_pix;
            use_reg   <= use_next;
        end
        if (ctl.out_en)
        begin
            if (use_reg)
            begin
                result_reg.blue  <= div255_round(num_b_reg);
                result_reg.green <= div255_round(num_g_reg);
                result_reg.red   <= div255_round(num_r_reg);
            end
            else
            begin
                result_reg <= bg_reg;
            end
        end
    end

    assign result = result_reg;

endmodule

### hw/rtl/alpha_icon_overlay.sv
// Top level of the alpha icon overlay: icon store, raster tracking and result pipeline.
// Depends on aio_pkg and aio_blend.
//
// Overview: mode 0 items load BGRA icon pixels in raster order into a single-port
// icon store (row stride ICON_MAX_W); mode 1 items are background BGR pixels, each
// giving one result with line and frame end flags. The block takes one item every
// clock while the result side does not hold it back. A background item is taken into
// the input register, then passes the icon store read and the channel products and
// reaches the output register with the rounded divide.
// A load item finishes when it leaves the input register and writes the store; it
// makes no result. The store is never cleared: a pixel covered by an icon entry
// that was never loaded gives undefined output. Configuration writes are always
// taken (cfg_ready is tied high) and should only be made while the block is idle.
module alpha_icon_overlay
#(
    parameter int ICON_MAX_W  = 64,
    parameter int ICON_MAX_H  = 64,
    parameter int IMAGE_MAX_W = 4096,
    parameter int IMAGE_MAX_H = 4096
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [aio_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [aio_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input items
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            mode,
    input  logic [7:0]                      blue,
    input  logic [7:0]                      green,
    input  logic [7:0]                      red,
    input  logic [7:0]                      alpha,
    // result items
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      out_blue,
    output logic [7:0]                      out_green,
    output logic [7:0]                      out_red,
    output logic                            line_end,
    output logic                            frame_end
);
    import aio_pkg::*;

    localparam int STORE_DEPTH = ICON_MAX_W * ICON_MAX_H;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LCOL_W      = $clog2(ICON_MAX_W);
    localparam int LROW_W      = $clog2(ICON_MAX_H);
    localparam int ISW_W       = $clog2(ICON_MAX_W + 1);
    localparam int ISH_W       = $clog2(ICON_MAX_H + 1);
    localparam int COL_W       = $clog2(IMAGE_MAX_W);
    localparam int ROW_W       = $clog2(IMAGE_MAX_H);
    localparam int WID_W       = $clog2(IMAGE_MAX_W + 1);
    localparam int HGT_W       = $clog2(IMAGE_MAX_H + 1);
    localparam int SZ_W        = (WID_W > HGT_W) ? WID_W : HGT_W;
    // signed working width for placement sums
    localparam int PL_W        = ((SZ_W > 13) ? SZ_W : 13) + 2;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [12:0]        image_width_reg;
    logic [12:0]        image_height_reg;
    logic [6:0]         icon_width_reg;
    logic [6:0]         icon_height_reg;
    logic signed [12:0] place_x_reg;
    logic signed [12:0] place_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            icon_width_reg   <= RST_ICON_WIDTH;
            icon_height_reg  <= RST_ICON_HEIGHT;
            place_x_reg      <= RST_PLACE_X;
            place_y_reg      <= RST_PLACE_Y;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                CFG_ICON_WIDTH:   icon_width_reg   <= cfg_data[6:0];
                CFG_ICON_HEIGHT:  icon_height_reg  <= cfg_data[6:0];
                CFG_PLACE_X:      place_x_reg      <= cfg_data;
                CFG_PLACE_Y:      place_y_reg      <= cfg_data;
                default:          ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Effective geometry: sizes clamped to their legal range and the
    // placement pulled inside the image. Re-registered every clock; an
    // item is first looked at in the cycle after acceptance, so a write
    // made while idle is always seen.
    // ---------------------------------------------------------------
    function automatic logic signed [PL_W-1:0] place_fit(input logic signed [PL_W-1:0] p,
                                                         input logic signed [PL_W-1:0] len,
                                                         input logic signed [PL_W-1:0] lim);
        logic signed [PL_W-1:0] q;
        q = p;
        if (q < 0)
            q = '0;
        if (q + len > lim)
            q = lim - len;
        if (q < 0)
            q = '0;
        return q;
    endfunction

    logic [WID_W-1:0]       w_next;
    logic [HGT_W-1:0]       h_next;
    logic [ISW_W-1:0]       iw_next;
    logic [ISH_W-1:0]       ih_next;
    logic signed [PL_W-1:0] x0_full;
    logic signed [PL_W-1:0] y0_full;

    always_comb
    begin
        w_next  = (image_width_reg == 13'd0) ? WID_W'(1) :
                  (int'(image_width_reg) > IMAGE_MAX_W) ? WID_W'(IMAGE_MAX_W) :
                  WID_W'(image_width_reg);
        h_next  = (image_height_reg == 13'd0) ? HGT_W'(1) :
                  (int'(image_height_reg) > IMAGE_MAX_H) ? HGT_W'(IMAGE_MAX_H) :
                  HGT_W'(image_height_reg);
        iw_next = (icon_width_reg == 7'd0) ? ISW_W'(1) :
                  (int'(icon_width_reg) > ICON_MAX_W) ? ISW_W'(ICON_MAX_W) :
                  ISW_W'(icon_width_reg);
        ih_next = (icon_height_reg == 7'd0) ? ISH_W'(1) :
                  (int'(icon_height_reg) > ICON_MAX_H) ? ISH_W'(ICON_MAX_H) :
                  ISH_W'(icon_height_reg);
        x0_full = place_fit(PL_W'(place_x_reg), PL_W'(iw_next), PL_W'(w_next));
        y0_full = place_fit(PL_W'(place_y_reg), PL_W'(ih_next), PL_W'(h_next));
    end

    logic [WID_W-1:0] w_reg;
    logic [HGT_W-1:0] h_reg;
    logic [COL_W-1:0] wm1_reg;      // last column of a line
    logic [ROW_W-1:0] hm1_reg;      // last line of a frame
    logic [ISW_W-1:0] iw_reg;
    logic [ISH_W-1:0] ih_reg;
    logic [COL_W-1:0] x0_reg;
    logic [ROW_W-1:0] y0_reg;
    logic [PL_W-1:0]  x_end_reg;    // first column past the icon
    logic [PL_W-1:0]  y_end_reg;

    always_ff @(posedge clk)
    begin
        w_reg     <= w_next;
        h_reg     <= h_next;
        wm1_reg   <= COL_W'(w_next - WID_W'(1));
        hm1_reg   <= ROW_W'(h_next - HGT_W'(1));
        iw_reg    <= iw_next;
        ih_reg    <= ih_next;
        x0_reg    <= COL_W'(x0_full);
        y0_reg    <= ROW_W'(y0_full);
        x_end_reg <= PL_W'(x0_full + PL_W'(iw_next));
        y_end_reg <= PL_W'(y0_full + PL_W'(ih_next));
    end

    // ---------------------------------------------------------------
    // Pipeline flow control. Each stage moves when the next one is
    // empty or moving; load items retire out of stage 1.
    // ---------------------------------------------------------------
    logic       s1_valid_reg;
    logic       s1_mode_reg;
    pix_t       s1_pix_reg;
    logic [7:0] s1_alpha_reg;

    logic       s2_valid_reg;
    pix_t       s2_bg_reg;
    logic [31:0] s2_icon_reg;
    logic       s2_cover_reg;
    logic       s2_le_reg;
    logic       s2_fe_reg;

    logic       s3_valid_reg;
    logic       s3_le_reg;
    logic       s3_fe_reg;

    logic       out_valid_reg;
    logic       line_end_reg;
    logic       frame_end_reg;

    logic       out_load;
    logic       s3_free;
    logic       s2_free;
    logic       s1_leave;
    logic       mem_we;
    logic       mem_re;

    assign out_load = !out_valid_reg || out_ready;
    assign s3_free  = !s3_valid_reg || out_load;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_leave = s1_valid_reg && (!s1_mode_reg || s2_free);
    assign in_ready = !s1_valid_reg || s1_leave;
    assign mem_we   = s1_leave && !s1_mode_reg;
    assign mem_re   = s1_leave && s1_mode_reg;

    // ---------------------------------------------------------------
    // Stage 1: input register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_mode_reg      <= mode;
            s1_pix_reg.blue  <= blue;
            s1_pix_reg.green <= green;
            s1_pix_reg.red   <= red;
            s1_alpha_reg     <= alpha;
        end
    end

    // ---------------------------------------------------------------
    // Load and raster counters
    // ---------------------------------------------------------------
    logic [LCOL_W-1:0] load_col_reg;
    logic [LROW_W-1:0] load_row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;

    logic              last_col;
    logic              last_row;
    logic              covered;
    logic [COL_W-1:0]  col_off;
    logic [ROW_W-1:0]  row_off;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] mem_addr;

    // a column or row at or past the end counts as the end (sizes may shrink)
    assign last_col = col_reg >= wm1_reg;
    assign last_row = row_reg >= hm1_reg;

    always_comb
    begin
        covered = (PL_W'(col_reg) >= PL_W'(x0_reg)) && (PL_W'(col_reg) < x_end_reg) &&
                  (PL_W'(col_reg) < PL_W'(w_reg)) &&
                  (PL_W'(row_reg) >= PL_W'(y0_reg)) && (PL_W'(row_reg) < y_end_reg) &&
                  (PL_W'(row_reg) < PL_W'(h_reg));
        col_off  = col_reg - x0_reg;
        row_off  = row_reg - y0_reg;
        // offsets are meaningful only when covered, where they lie inside the icon
        rd_addr  = ADDR_W'(ADDR_W'(LROW_W'(row_off)) * ADDR_W'(ICON_MAX_W))
                   + ADDR_W'(LCOL_W'(col_off));
        wr_addr  = ADDR_W'(ADDR_W'(load_row_reg) * ADDR_W'(ICON_MAX_W))
                   + ADDR_W'(load_col_reg);
        mem_addr = s1_mode_reg ? rd_addr : wr_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_col_reg <= '0;
            load_row_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else
        begin
            if (mem_we)
            begin
                if (int'(load_col_reg) + 1 >= int'(iw_reg))
                begin
                    load_col_reg <= '0;
                    if (int'(load_row_reg) + 1 >= int'(ih_reg))
                        load_row_reg <= '0;
                    else
                        load_row_reg <= LROW_W'(load_row_reg + 1'b1);
                end
                else
                begin
                    load_col_reg <= LCOL_W'(load_col_reg + 1'b1);
                end
            end
            if (mem_re)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    if (last_row)
                        row_reg <= '0;
                    else
                        row_reg <= ROW_W'(row_reg + 1'b1);
                end
                else
                begin
                    col_reg <= COL_W'(col_reg + 1'b1);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Icon store: single port, one access per item in item order, so a
    // load is always seen by any later background read.
    // ---------------------------------------------------------------
    logic [31:0] icon_mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            icon_mem[mem_addr] <= {s1_alpha_reg, s1_pix_reg.red, s1_pix_reg.green,
                                   s1_pix_reg.blue};
        if (mem_re)
            s2_icon_reg <= icon_mem[mem_addr];
    end

    // ---------------------------------------------------------------
    // Stage 2: icon word, background and flags
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            s2_bg_reg    <= s1_pix_reg;
            s2_cover_reg <= covered;
            s2_le_reg    <= last_col;
            s2_fe_reg    <= last_col && last_row;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3 and output register: valids and flags here, colour
    // channels inside the blend datapath
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_free)
                s2_valid_reg <= mem_re;
            if (s3_free)
                s3_valid_reg <= s2_valid_reg;
            if (out_load)
                out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s3_free)
        begin
            s3_le_reg <= s2_le_reg;
            s3_fe_reg <= s2_fe_reg;
        end
        if (s3_valid_reg && out_load)
        begin
            line_end_reg  <= s3_le_reg;
            frame_end_reg <= s3_fe_reg;
        end
    end

    blend_ctl_t bl_ctl;
    pix_t       icon_pix;
    pix_t       blend_pix;

    assign bl_ctl.mul_en  = s2_valid_reg && s3_free;
    assign bl_ctl.out_en  = s3_valid_reg && out_load;
    assign icon_pix.blue  = s2_icon_reg[7:0];
    assign icon_pix.green = s2_icon_reg[15:8];
    assign icon_pix.red   = s2_icon_reg[23:16];

    aio_blend u_blend
    (
        .clk        (clk),
        .ctl        (bl_ctl),
        .icon_pix   (icon_pix),
        .icon_alpha (s2_icon_reg[31:24]),
        .covered    (s2_cover_reg),
        .bg_pix     (s2_bg_reg),
        .result     (blend_pix)
    );

    assign out_valid = out_valid_reg;
    assign out_blue  = blend_pix.blue;
    assign out_green = blend_pix.green;
    assign out_red   = blend_pix.red;
    assign line_end  = line_end_reg;
    assign frame_end = frame_end_reg;

endmodule

### tb/aio_overlay_checker.sv
`timescale 1ns / 100ps
// Checker for alpha_icon_overlay: follows the config, input and result channels and
// predicts every composited pixel. Depends on aio_pkg for the register codes and resets.
module aio_overlay_checker
#(
    parameter int ICON_MAX_W  = 64,
    parameter int ICON_MAX_H  = 64,
    parameter int IMAGE_MAX_W = 4096,
    parameter int IMAGE_MAX_H = 4096
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [aio_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [aio_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            mode,
    input  logic [7:0]                      blue,
    input  logic [7:0]                      green,
    input  logic [7:0]                      red,
    input  logic [7:0]                      alpha,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [7:0]                      out_blue,
    input  logic [7:0]                      out_green,
    input  logic [7:0]                      out_red,
    input  logic                            line_end,
    input  logic                            frame_end,
    output int                              pending,
    output int                              failures
);

    localparam int STORE_DEPTH = ICON_MAX_W * ICON_MAX_H;

    typedef struct packed {
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
        logic       line_last;
        logic       frame_last;
    } composite_t;

    composite_t  composite_q[$];
    logic [31:0] icon_mem [STORE_DEPTH];
    int          load_col;
    int          load_row;
    int          scan_col;
    int          scan_row;
    int          err_count = 0;
    int          result_no = 0;

    logic [12:0] img_w_q;
    logic [12:0] img_h_q;
    logic [6:0]  icon_w_q;
    logic [6:0]  icon_h_q;
    logic [12:0] place_x_q;
    logic [12:0] place_y_q;

    function automatic int clamp_size(input int v, input int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // keep the icon inside the frame; an icon wider than the frame sits at 0
    function automatic int fit_origin(input int want, input int span, input int lim);
        int o;
        o = (want < 0) ? 0 : want;
        if (o + span > lim)
            o = lim - span;
        if (o < 0)
            o = 0;
        return o;
    endfunction

    function automatic logic [7:0] mix_channel(input int p, input int bg, input int a);
        return 8'((p * a + bg * (255 - a) + 127) / 255);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] overlay check: %s", $time, msg);
        err_count++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %h want %h",
                                      result_no, name, got, want));
    endtask

    task automatic store_icon_pixel(input logic [7:0] b, g, r, a);
        int iw;
        int ih;
        iw = clamp_size(int'(icon_w_q), ICON_MAX_W);
        ih = clamp_size(int'(icon_h_q), ICON_MAX_H);
        icon_mem[(load_row * ICON_MAX_W + load_col) % STORE_DEPTH] = {a, r, g, b};
        if (load_col + 1 >= iw) begin
            load_col = 0;
            load_row = (load_row + 1 >= ih) ? 0 : load_row + 1;
        end else begin
            load_col++;
        end
    endtask

    task automatic composite_pixel(input logic [7:0] b, g, r);
        int         iw;
        int         ih;
        int         w;
        int         h;
        int         x0;
        int         y0;
        int         a;
        logic [31:0] px;
        composite_t res;
        iw = clamp_size(int'(icon_w_q), ICON_MAX_W);
        ih = clamp_size(int'(icon_h_q), ICON_MAX_H);
        w  = clamp_size(int'(img_w_q), IMAGE_MAX_W);
        h  = clamp_size(int'(img_h_q), IMAGE_MAX_H);
        x0 = fit_origin(int'($signed(place_x_q)), iw, w);
        y0 = fit_origin(int'($signed(place_y_q)), ih, h);
        res.b = b;
        res.g = g;
        res.r = r;
        res.line_last  = scan_col >= w - 1;
        res.frame_last = res.line_last && scan_row >= h - 1;
        if (scan_col >= x0 && scan_col < x0 + iw && scan_col < w &&
            scan_row >= y0 && scan_row < y0 + ih && scan_row < h) begin
            px = icon_mem[((scan_row - y0) * ICON_MAX_W + (scan_col - x0)) % STORE_DEPTH];
            a  = int'(px[31:24]);
            // fully transparent icon pixels leave the background alone
            if (a > 0) begin
                res.b = mix_channel(int'(px[7:0]), int'(b), a);
                res.g = mix_channel(int'(px[15:8]), int'(g), a);
                res.r = mix_channel(int'(px[23:16]), int'(r), a);
            end
        end
        composite_q = {composite_q, res};
        if (res.line_last) begin
            scan_col = 0;
            scan_row = (scan_row >= h - 1) ? 0 : scan_row + 1;
        end else begin
            scan_col++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        composite_t want;
        if (!rst_n) begin
            composite_q.delete();
            load_col  = 0;
            load_row  = 0;
            scan_col  = 0;
            scan_row  = 0;
            img_w_q   = aio_pkg::RST_IMAGE_WIDTH;
            img_h_q   = aio_pkg::RST_IMAGE_HEIGHT;
            icon_w_q  = aio_pkg::RST_ICON_WIDTH;
            icon_h_q  = aio_pkg::RST_ICON_HEIGHT;
            place_x_q = aio_pkg::RST_PLACE_X;
            place_y_q = aio_pkg::RST_PLACE_Y;
            pending  <= 0;
            failures <= 0;
        end else begin
            // results first: one arriving now is always older than an item taken now
            if (out_valid && out_ready) begin
                if (composite_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, blue %h", out_blue));
                end else begin
                    want = composite_q.pop_front();
                    compare_field("out_blue", out_blue, want.b);
                    compare_field("out_green", out_green, want.g);
                    compare_field("out_red", out_red, want.r);
                    compare_field("line_end", 8'(line_end), 8'(want.line_last));
                    compare_field("frame_end", 8'(frame_end), 8'(want.frame_last));
                end
                result_no++;
            end
            if (cfg_valid && cfg_ready) begin
                case (aio_pkg::cfg_idx_t'(cfg_index))
                    aio_pkg::CFG_IMAGE_WIDTH:  img_w_q   = cfg_data;
                    aio_pkg::CFG_IMAGE_HEIGHT: img_h_q   = cfg_data;
                    aio_pkg::CFG_ICON_WIDTH:   icon_w_q  = cfg_data[6:0];
                    aio_pkg::CFG_ICON_HEIGHT:  icon_h_q  = cfg_data[6:0];
                    aio_pkg::CFG_PLACE_X:      place_x_q = cfg_data;
                    aio_pkg::CFG_PLACE_Y:      place_y_q = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready) begin
                if (mode)
                    composite_pixel(blue, green, red);
                else
                    store_icon_pixel(blue, green, red, alpha);
            end
            pending  <= composite_q.size();
            failures <= err_count;
        end
    end

endmodule

### tb/alpha_icon_overlay_tb.sv
`timescale 1ns / 100ps
// Top of the alpha_icon_overlay testbench: clock, reset, stimulus and verdict.
// Depends on aio_pkg, alpha_icon_overlay and aio_overlay_checker.
module alpha_icon_overlay_tb;

    import aio_pkg::*;

    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int RANDOM_ITEMS  = 600;
    localparam int DRAIN_CYCLES  = 10;   // load items finish when they leave the input register and write the store

    // Loads only ever land in the top-left ICON_FILL x ICON_FILL corner of the store,
    // and random icon sizes never exceed it, so every read hits a loaded entry.
    localparam int ICON_FILL = 8;

    // kinds of item run
    localparam int RUN_LOAD   = 0;
    localparam int RUN_PIXELS = 1;
    localparam int RUN_NOISE  = 2;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    logic                    mode      = 1'b0;
    logic [7:0]              blue      = 8'd0;
    logic [7:0]              green     = 8'd0;
    logic [7:0]              red       = 8'd0;
    logic [7:0]              alpha     = 8'd0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [7:0]              out_blue;
    logic [7:0]              out_green;
    logic [7:0]              out_red;
    logic                    line_end;
    logic                    frame_end;

    int expected_left;
    int fail_count;

    // stall chance in percent, shared by both sides; zero gives a smooth stretch
    int idle_pct    = 0;
    int ready_hold  = 0;
    int sent_items  = 0;

    // local view of the settings, only used to shape runs
    logic [12:0] cur_img_w  = RST_IMAGE_WIDTH;
    logic [12:0] cur_img_h  = RST_IMAGE_HEIGHT;
    logic [6:0]  cur_icon_w = RST_ICON_WIDTH;
    logic [6:0]  cur_icon_h = RST_ICON_HEIGHT;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    alpha_icon_overlay u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .blue      (blue),
        .green     (green),
        .red       (red),
        .alpha     (alpha),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_blue  (out_blue),
        .out_green (out_green),
        .out_red   (out_red),
        .line_end  (line_end),
        .frame_end (frame_end)
    );

    aio_overlay_checker u_check
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .blue      (blue),
        .green     (green),
        .red       (red),
        .alpha     (alpha),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_blue  (out_blue),
        .out_green (out_green),
        .out_red   (out_red),
        .line_end  (line_end),
        .frame_end (frame_end),
        .pending   (expected_left),
        .failures  (fail_count)
    );

    // Result side back-pressure: random bursts of out_ready low, none while idle_pct is 0
    always @(posedge clk)
    begin
        if (idle_pct == 0)
        begin
            ready_hold <= 0;
            out_ready  <= 1'b1;
        end
        else if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
        end
        else if ($urandom_range(0, 99) < idle_pct)
        begin
            ready_hold <= $urandom_range(0, 11);
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Watchdog: a hung or silent block ends the run here
    initial
    begin : watchdog
        int n;
        for (n = 0; n < LIMIT_CYCLES; n++)
            @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    // channel value with the extremes weighted up
    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom());
        endcase
    endfunction

    function automatic logic [12:0] pick_img(input int hi);
        if ($urandom_range(0, 9) < 7)
            return 13'($urandom_range(1, hi));
        case ($urandom_range(0, 4))
            0:       return 13'd0;
            1:       return 13'd1;
            2:       return 13'd4096;
            3:       return 13'h1FFF;
            default: return 13'($urandom());
        endcase
    endfunction

    function automatic logic [6:0] pick_icon();
        if ($urandom_range(0, 9) < 7)
            return 7'($urandom_range(1, 6));
        case ($urandom_range(0, 3))
            0:       return 7'd0;
            1:       return 7'(ICON_FILL);
            2:       return 7'd1;
            default: return 7'($urandom_range(1, ICON_FILL));
        endcase
    endfunction

    function automatic logic [12:0] pick_place();
        if ($urandom_range(0, 9) < 7)
            return 13'(int'($urandom_range(0, 17)) - 3);
        case ($urandom_range(0, 2))
            0:       return 13'h1000;   // most negative
            1:       return 13'h0FFF;   // most positive
            default: return 13'($urandom());
        endcase
    endfunction

    function automatic int fit_count(input int v, input int hi);
        if (v < 1)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    // One item: optional gap, then hold valid until the block takes it
    task automatic send_item(input logic m, input logic [7:0] b, g, r, a);
        int gap;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        blue     <= b;
        green    <= g;
        red      <= r;
        alpha    <= a;
        do
            @(posedge clk);
        while (!in_ready);
        sent_items++;
    endtask

    task automatic send_run(input int kind, input int n);
        int  i;
        for (i = 0; i < n; i++)
        begin
            case (kind)
                RUN_LOAD:   send_item(1'b0, pick_channel(), pick_channel(), pick_channel(),
                                      pick_channel());
                RUN_PIXELS: send_item(1'b1, pick_channel(), pick_channel(), pick_channel(),
                                      pick_channel());
                default:    send_item(1'($urandom()), pick_channel(), pick_channel(),
                                      pick_channel(), pick_channel());
            endcase
        end
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input logic [12:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // bit i of sel picks register i
    task automatic set_config(input logic [12:0] w, h, input logic [6:0] iw, ih,
                              input logic [12:0] px, py, input logic [5:0] sel);
        if (sel[0])
        begin
            cfg_write(CFG_IMAGE_WIDTH, w);
            cur_img_w = w;
        end
        if (sel[1])
        begin
            cfg_write(CFG_IMAGE_HEIGHT, h);
            cur_img_h = h;
        end
        if (sel[2])
        begin
            cfg_write(CFG_ICON_WIDTH, 13'(iw));
            cur_icon_w = iw;
        end
        if (sel[3])
        begin
            cfg_write(CFG_ICON_HEIGHT, 13'(ih));
            cur_icon_h = ih;
        end
        if (sel[4])
            cfg_write(CFG_PLACE_X, px);
        if (sel[5])
            cfg_write(CFG_PLACE_Y, py);
        cfg_valid <= 1'b0;
    endtask

    // Sender holds off until every expected result is back, then lets loads settle
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_left != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int base;
        int phase_items;
        int n;
        int roll;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the ICON_FILL x ICON_FILL corner of the store once, so no later read
        // can land on an entry that was never loaded.
        idle_pct = 15;
        set_config(RST_IMAGE_WIDTH, RST_IMAGE_HEIGHT, 7'(ICON_FILL), 7'(ICON_FILL),
                   RST_PLACE_X, RST_PLACE_Y, 6'h0C);
        send_item(1'b0, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_item(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_item(1'b0, 8'hFF, 8'h00, 8'hFF, 8'h00);
        send_item(1'b0, 8'h00, 8'hFF, 8'h00, 8'h80);
        send_run(RUN_LOAD, ICON_FILL * ICON_FILL - 4);
        drain();

        // Directed: placement below zero on both axes, tiny frame, extreme colours
        set_config(13'd4, 13'd2, 7'd2, 7'd2, 13'h1000, 13'h1FFF, 6'h3F);
        send_item(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'h00);
        send_item(1'b1, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_item(1'b1, 8'h00, 8'hFF, 8'h00, 8'h00);
        send_item(1'b1, 8'hFF, 8'h00, 8'hFF, 8'hFF);
        send_item(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_item(1'b1, 8'h80, 8'h7F, 8'h01, 8'hAA);
        send_item(1'b1, 8'h7F, 8'h80, 8'hFE, 8'h55);
        drain();

        // Directed: icon larger than the frame (width over the store limit),
        // placement past the far edges
        set_config(13'd3, 13'd2, 7'h7F, 7'd64, 13'h0FFF, 13'h0FFF, 6'h3F);
        send_run(RUN_PIXELS, 6);
        drain();

        // Directed: zero sizes clamp to one; every pixel ends a line and the frame,
        // and the load position wraps on each item
        set_config(13'd0, 13'd0, 7'd0, 7'd0, 13'd0, 13'd0, 6'h3F);
        send_item(1'b0, 8'h12, 8'h34, 8'h56, 8'hFF);
        send_item(1'b0, 8'hAB, 8'hCD, 8'hEF, 8'h40);
        send_item(1'b1, 8'h00, 8'hFF, 8'h00, 8'h00);
        send_item(1'b1, 8'hFF, 8'h00, 8'hFF, 8'hFF);
        drain();

        // Random phases: mostly whole icon loads and whole frames, some noise
        base = sent_items;
        while (sent_items - base < RANDOM_ITEMS)
        begin
            drain();
            case ($urandom_range(0, 3))
                0:       idle_pct = 0;
                1:       idle_pct = 8;
                2:       idle_pct = 20;
                default: idle_pct = 40;
            endcase
            set_config(pick_img(12), pick_img(6), pick_icon(), pick_icon(),
                       pick_place(), pick_place(), 6'($urandom_range(1, 63)));
            phase_items = 0;
            while (phase_items < 60)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 20)
                begin
                    n = fit_count(int'(cur_icon_w), 64) * fit_count(int'(cur_icon_h), 64);
                    n = (n > 64) ? 64 : n;
                    send_run(RUN_LOAD, n);
                end
                else if (roll < 85)
                begin
                    n = fit_count(int'(cur_img_w), 4096) * fit_count(int'(cur_img_h), 4096);
                    n = (n > 100) ? 100 : n;
                    send_run(RUN_PIXELS, n);
                end
                else
                begin
                    n = $urandom_range(1, 8);
                    send_run(RUN_NOISE, n);
                end
                phase_items += n;
            end
        end
        drain();

        // Oversized width clamps to the widest line; the icon sits early in line 0
        idle_pct = 5;
        set_config(13'h1FFF, 13'd2, 7'(ICON_FILL), 7'(ICON_FILL), 13'd2, 13'h1FF9, 6'h3F);
        send_run(RUN_PIXELS, 40);
        drain();

        // Closing stretch with no stalls on either side
        idle_pct = 0;
        set_config(13'd7, 13'd3, 7'd3, 7'd2, 13'd2, 13'd1, 6'h3F);
        send_run(RUN_LOAD, 6);
        send_run(RUN_PIXELS, 42);
        send_run(RUN_NOISE, 20);
        drain();

        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
